// ===== hw/rtl/tscd_pkg.sv =====
// ----------------------------------------------------------------------------
// tscd_pkg: shared types and constants
// Frame length, status and presence codes, queue record and the CRC-8 step.
// ----------------------------------------------------------------------------
package tscd_pkg;

  // scratchpad frame: data bytes followed by one CRC byte
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  localparam int unsigned LIMIT_W = 4;
  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = LIMIT_W'(10);
  localparam logic [LIMIT_W-1:0] MISMATCH_MAX    = {LIMIT_W{1'b1}};

  // reflected x^8+x^5+x^4+1
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // operation codes
  localparam logic OP_PRESENCE = 1'b0;
  localparam logic OP_BYTE     = 1'b1;

  // presence codes
  localparam logic [1:0] PRES_OK    = 2'd0;
  localparam logic [1:0] PRES_SHORT = 2'd1;
  localparam logic [1:0] PRES_NONE  = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_SHORT     = 3'd1;
  localparam status_t ST_CRC_FINAL = 3'd2;
  localparam status_t ST_NO_DEVICE = 3'd3;
  localparam status_t ST_RETRY     = 3'd4;

  // one pending result between front and back
  typedef struct packed {
    status_t     status;
    logic [15:0] raw;
  } rec_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/tscd_in_if.sv =====
// ----------------------------------------------------------------------------
// tscd_in_if: input item channel
// Valid/ready channel carrying the operation, presence code and data byte.
// ----------------------------------------------------------------------------
interface tscd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [1:0] presence_code;
  logic [7:0] data_byte;

  modport source (output valid, operation, presence_code, data_byte, input ready);
  modport sink   (input valid, operation, presence_code, data_byte, output ready);
endinterface

// ===== hw/rtl/tscd_out_if.sv =====
// ----------------------------------------------------------------------------
// tscd_out_if: result item channel
// Valid/ready channel carrying the status and the temperature in tenths.
// ----------------------------------------------------------------------------
interface tscd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] temperature_tenths;

  modport source (output valid, status, temperature_tenths, input ready);
  modport sink   (input valid, status, temperature_tenths, output ready);
endinterface

// ===== hw/rtl/temp_scratchpad_crc_decoder.sv =====
// ----------------------------------------------------------------------------
// temp_scratchpad_crc_decoder: scratchpad CRC check and temperature decode
// Checks a sensor scratchpad frame with CRC-8 and reports status/temperature.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one item per handshake: a presence result (operation 0)
//   or one scratchpad byte (operation 1). Send a presence result, then the
//   frame bytes in order; the last byte is the CRC over the ones before it.
//   out_chan returns one item per shorted bus, missing device, or frame end:
//   status plus temperature in tenths of a degree (zero unless status ok).
//   cfg_we/cfg_wdata write retry_limit; write it only while the block is idle.
// Timing:
//   One item is accepted per cycle while the result queue has room. The edge
//   that accepts the causing item writes its result into the result queue;
//   the output register is loaded from the queue, after the temperature
//   scaling, when it is empty or being drained.
// Reset:
//   rst_n (synchronous, active low) restarts the frame, clears the mismatch
//   count and loads retry_limit with 10. The queue and output empty.
// Stall:
//   A stalled receiver holds the output item; results collect in a
//   four-entry queue, and in_chan.ready drops only when that queue is full.
// ----------------------------------------------------------------------------
module temp_scratchpad_crc_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  tscd_in_if.sink                     in_chan,
  tscd_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [tscd_pkg::LIMIT_W-1:0] cfg_wdata
);

  logic           push_valid;
  logic           push_ready;
  tscd_pkg::rec_t push_rec;
  logic           pop_valid;
  logic           pop_ready;
  tscd_pkg::rec_t pop_rec;

  // front: frame position, CRC, mismatch count and classification
  tscd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (push_ready)
  );

  // queue: decouple intake from the result side
  tscd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_rec    (pop_rec),
    .pop_ready  (pop_ready)
  );

  // back: scale raw word to tenths and hold the result for the receiver
  tscd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_rec   (pop_rec),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule

// ===== hw/rtl/tscd_front.sv =====
// ----------------------------------------------------------------------------
// tscd_front: item intake and classification
// Tracks the frame position and running CRC, counts mismatches and pushes
// one record per result into the queue.
// ----------------------------------------------------------------------------
module tscd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  tscd_in_if.sink                     in_chan,
  input  logic                        cfg_we,
  input  logic [tscd_pkg::LIMIT_W-1:0] cfg_wdata,
  output logic                        push_valid,
  output tscd_pkg::rec_t              push_rec,
  input  logic                        push_ready
);

  logic [tscd_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]                   crc_r, crc_nxt;
  logic [7:0]                   lo_r, lo_nxt;
  logic [7:0]                   hi_r, hi_nxt;
  logic [tscd_pkg::LIMIT_W-1:0] mis_r, mis_nxt;
  logic [tscd_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic [tscd_pkg::LIMIT_W-1:0] mis_inc;
  logic                         take;

  // accept whenever the queue has room
  assign in_chan.ready = push_ready;
  assign take          = in_chan.valid & push_ready;
  assign mis_inc       = (mis_r < tscd_pkg::MISMATCH_MAX) ? mis_r + 1'b1 : mis_r;

  always_comb begin
    pos_nxt         = pos_r;
    crc_nxt         = crc_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mis_nxt         = mis_r;
    limit_nxt       = cfg_we ? cfg_wdata : limit_r;
    push_valid      = 1'b0;
    push_rec.status = tscd_pkg::ST_OK;
    push_rec.raw    = {hi_r, lo_r};
    if (take) begin
      if (in_chan.operation == tscd_pkg::OP_PRESENCE) begin
        pos_nxt = '0;
        crc_nxt = '0;
        case (in_chan.presence_code)
          tscd_pkg::PRES_OK: begin
          end
          tscd_pkg::PRES_SHORT: begin
            push_valid      = 1'b1;
            push_rec.status = tscd_pkg::ST_SHORT;
          end
          default: begin
            push_valid      = 1'b1;
            push_rec.status = tscd_pkg::ST_NO_DEVICE;
          end
        endcase
      end else if (pos_r < tscd_pkg::LAST_POS) begin
        if (pos_r == '0) lo_nxt = in_chan.data_byte;
        if (pos_r == tscd_pkg::POS_W'(1)) hi_nxt = in_chan.data_byte;
        crc_nxt = tscd_pkg::crc8_update(crc_r, in_chan.data_byte);
        pos_nxt = pos_r + 1'b1;
      end else begin
        pos_nxt    = '0;
        crc_nxt    = '0;
        push_valid = 1'b1;
        if (crc_r == in_chan.data_byte) begin
          mis_nxt         = '0;
          push_rec.status = tscd_pkg::ST_OK;
        end else if (mis_inc < limit_r) begin
          mis_nxt         = mis_inc;
          push_rec.status = tscd_pkg::ST_RETRY;
        end else begin
          mis_nxt         = '0;
          push_rec.status = tscd_pkg::ST_CRC_FINAL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      crc_r   <= '0;
      mis_r   <= '0;
      limit_r <= tscd_pkg::RETRY_LIMIT_RST;
    end else begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      mis_r   <= mis_nxt;
      limit_r <= limit_nxt;
    end
  end

  // temperature bytes hold payload only
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

endmodule

// ===== hw/rtl/tscd_queue.sv =====
// ----------------------------------------------------------------------------
// tscd_queue: short result queue
// Register FIFO that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module tscd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  tscd_pkg::rec_t push_rec,
  output logic           push_ready,
  output logic           pop_valid,
  output tscd_pkg::rec_t pop_rec,
  input  logic           pop_ready
);

  tscd_pkg::rec_t              slot_r [tscd_pkg::QUEUE_DEPTH];
  logic [tscd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tscd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tscd_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = (cnt_r != tscd_pkg::QCNT_W'(tscd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_rec    = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_rec;
  end

endmodule

// ===== hw/rtl/tscd_back.sv =====
// ----------------------------------------------------------------------------
// tscd_back: temperature decode and result register
// Pops a record, scales the raw word to tenths and holds it for the receiver.
// ----------------------------------------------------------------------------
module tscd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  input  tscd_pkg::rec_t pop_rec,
  output logic           pop_ready,
  tscd_out_if.source     out_chan
);

  logic                  out_valid_r, out_valid_nxt;
  tscd_pkg::status_t     status_r;
  logic signed [15:0]    tenths_r;
  logic signed [15:0]    whole;
  logic signed [15:0]    tenths;
  logic                  load;

  // refill the output register when empty or being drained
  assign pop_ready = ~out_valid_r | out_chan.ready;
  assign load      = pop_valid & pop_ready;

  always_comb begin
    // whole degrees: arithmetic shift of the signed raw word
    whole  = $signed(pop_rec.raw) >>> 4;
    tenths = (whole <<< 3) + (whole <<< 1) + (pop_rec.raw[3] ? 16'sd5 : 16'sd0);
    if (pop_rec.status != tscd_pkg::ST_OK) tenths = '0;
    out_valid_nxt = load | (out_valid_r & ~out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= pop_rec.status;
      tenths_r <= tenths;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.status             = status_r;
  assign out_chan.temperature_tenths = tenths_r;

endmodule

// ===== hw/rtl/tscd_checker.sv =====
// ----------------------------------------------------------------------------
// tscd_checker: port-level assertions
// Watches the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
module tscd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_tenths
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_tenths))
    else $error("stalled result changed or dropped");

  // drop the output after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // keep the temperature zero unless the status is ok
  a_tenths_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != tscd_pkg::ST_OK) |-> out_tenths == '0)
    else $error("temperature given with a failing status");

  // keep the status within the assigned codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= tscd_pkg::ST_RETRY)
    else $error("unassigned status code");

endmodule

bind temp_scratchpad_crc_decoder tscd_checker u_tscd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_tenths (out_chan.temperature_tenths)
);
